### sv/qtn_pkg.sv
// Package for the quoted text normalizer.
// Holds character codes and the inline tag name table; no dependencies.
package qtn_pkg;

	typedef logic [7:0] ascii_t;

	localparam ascii_t CH_LT    = 8'h3C;
	localparam ascii_t CH_GT    = 8'h3E;
	localparam ascii_t CH_SLASH = 8'h2F;
	localparam ascii_t CH_CR    = 8'h0D;
	localparam ascii_t CH_LF    = 8'h0A;
	localparam ascii_t CH_SP    = 8'h20;
	localparam ascii_t CH_TAB   = 8'h09;
	localparam ascii_t CH_UA    = 8'h41;
	localparam ascii_t CH_UZ    = 8'h5A;
	localparam ascii_t CH_LA    = 8'h61;
	localparam ascii_t CH_LZ    = 8'h7A;
	localparam ascii_t CH_D0    = 8'h30;
	localparam ascii_t CH_D9    = 8'h39;
	localparam ascii_t CASE_BIT = 8'h20;

	localparam int INLINE_COUNT = 15;
	localparam int NAME_MAX     = 6;

	typedef logic [NAME_MAX-1:0][7:0] tag_name_t;
	typedef logic [2:0]               name_len_t;

	// Leftmost letter sits in the top byte.
	localparam tag_name_t INL_NAME [INLINE_COUNT] = '{
		{"b", 40'h0}, {"i", 40'h0}, {"u", 40'h0}, {"s", 40'h0},
		{"em", 32'h0}, "strong", {"span", 16'h0}, {"a", 40'h0},
		{"font", 16'h0}, {"small", 8'h0}, {"big", 24'h0},
		{"sub", 24'h0}, {"sup", 24'h0}, {"code", 16'h0}, {"mark", 16'h0}
	};

	localparam name_len_t INL_LEN [INLINE_COUNT] = '{
		3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd6, 3'd4, 3'd1,
		3'd4, 3'd5, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4
	};

endpackage

### sv/quoted_text_normalizer.sv
// Quoted text normalizer: lower-cases text, folds blanks, strips HTML tags or quote markers.
// Depends on qtn_pkg.
//
// One character is taken per cycle through an input register, decoded in a single
// combinational pass, and its results land in an output register. A character that
// flushes a pending space yields two results and holds the input register while the
// space goes out; otherwise the block sustains one character per cycle when not stalled.
// While a result waits to be taken, only characters that yield no result can pass.
// html_mode may be written only while no character is in flight.
module quoted_text_normalizer #(
	parameter int TAG_CHARS_MAX = 6,
	parameter int CHAR_BITS     = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CHAR_BITS-1:0] in_char,
	input  logic                 text_start,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CHAR_BITS-1:0] out_char,
	output logic                 last_of_item
);
	import qtn_pkg::*;

	localparam int LENW = $clog2(TAG_CHARS_MAX + 2);
	localparam logic [LENW-1:0] LEN_MAX = LENW'(TAG_CHARS_MAX);

	logic                 html_mode_q;
	logic                 valid_s1;
	logic [CHAR_BITS-1:0] char_s1;
	logic                 start_s1;
	logic                 phase_q;

	logic                 line_start_q, inside_tag_q, space_pending_q, emitted_any_q;
	logic                 tag_name_closed_q;
	logic [LENW-1:0]      tag_length_q;
	ascii_t               tag_chars_q [TAG_CHARS_MAX];

	logic                 out_valid_q, out_last_q;
	logic [CHAR_BITS-1:0] out_char_q;

	logic                 e_line_start, e_inside, e_space, e_emitted, e_closed;
	logic [LENW-1:0]      e_len;
	logic                 is_ascii, is_upper, is_alnum;
	logic [7:0]           cb;
	logic [CHAR_BITS-1:0] lower_c;
	logic                 tag_inline;
	logic                 emit, need_space;
	logic                 n_line_start, n_inside, n_space, n_emitted, n_closed;
	logic [LENW-1:0]      n_len;
	logic                 tag_wr;
	logic                 out_ok, out_load, consume, in_xfer;

	assign e_line_start = start_s1 | line_start_q;
	assign e_inside     = !start_s1 & inside_tag_q;
	assign e_space      = !start_s1 & space_pending_q;
	assign e_emitted    = !start_s1 & emitted_any_q;
	assign e_closed     = !start_s1 & tag_name_closed_q;
	assign e_len        = start_s1 ? '0 : tag_length_q;

	assign is_ascii = char_s1 < CHAR_BITS'(128);
	assign cb       = char_s1[7:0];
	assign is_upper = is_ascii && cb >= CH_UA && cb <= CH_UZ;
	assign is_alnum = is_upper || (is_ascii && cb >= CH_LA && cb <= CH_LZ)
	                || (is_ascii && cb >= CH_D0 && cb <= CH_D9);
	assign lower_c  = is_upper ? (char_s1 | CHAR_BITS'(CASE_BIT)) : char_s1;

	always_comb begin
		tag_inline = 1'b0;
		for (int k = 0; k < INLINE_COUNT; k++) begin
			logic m;
			m = (e_len == LENW'(INL_LEN[k]));
			for (int j = 0; j < NAME_MAX; j++) begin
				if (j < int'(INL_LEN[k]) && tag_chars_q[j] != INL_NAME[k][NAME_MAX-1-j])
					m = 1'b0;
			end
			if (m)
				tag_inline = 1'b1;
		end
	end

	always_comb begin
		n_line_start = e_line_start;
		n_inside     = e_inside;
		n_space      = e_space;
		n_emitted    = e_emitted;
		n_closed     = e_closed;
		n_len        = e_len;
		tag_wr       = 1'b0;
		emit         = 1'b0;
		need_space   = 1'b0;
		if (html_mode_q && char_s1 == CHAR_BITS'(CH_LT)) begin
			n_inside = 1'b1;
			n_len    = '0;
			n_closed = 1'b0;
		end else if (html_mode_q && char_s1 == CHAR_BITS'(CH_GT) && e_inside) begin
			n_inside = 1'b0;
			if (!tag_inline)
				n_space = 1'b1;
		end else if (e_inside) begin
			if (!e_closed) begin
				if (char_s1 == CHAR_BITS'(CH_SLASH) && e_len == '0) begin
					n_len = e_len;
				end else if (is_alnum) begin
					tag_wr = e_len < LEN_MAX;
					if (e_len <= LEN_MAX)
						n_len = e_len + 1'b1;
				end else begin
					n_closed = 1'b1;
				end
			end
		end else if (char_s1 == CHAR_BITS'(CH_CR) || char_s1 == CHAR_BITS'(CH_LF)) begin
			n_line_start = 1'b1;
			n_space      = 1'b1;
		end else if (char_s1 == CHAR_BITS'(CH_SP) || char_s1 == CHAR_BITS'(CH_TAB)) begin
			n_space = 1'b1;
		end else if (!html_mode_q && e_line_start && char_s1 == CHAR_BITS'(CH_GT)) begin
			n_line_start = e_line_start;
		end else begin
			emit         = 1'b1;
			need_space   = e_space && e_emitted;
			n_line_start = 1'b0;
			n_space      = 1'b0;
			n_emitted    = 1'b1;
		end
	end

	assign out_ok   = !out_valid_q || !out_stall;
	assign out_load = valid_s1 && emit && out_ok;
	assign consume  = valid_s1 && (!emit || (out_ok && (!need_space || phase_q)));
	assign in_stall = valid_s1 && !consume;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			html_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			html_mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1  <= in_char;
			start_s1 <= text_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q      <= 1'b1;
			inside_tag_q      <= 1'b0;
			space_pending_q   <= 1'b0;
			emitted_any_q     <= 1'b0;
			tag_name_closed_q <= 1'b0;
			tag_length_q      <= '0;
			phase_q           <= 1'b0;
		end else begin
			if (consume) begin
				line_start_q      <= n_line_start;
				inside_tag_q      <= n_inside;
				space_pending_q   <= n_space;
				emitted_any_q     <= n_emitted;
				tag_name_closed_q <= n_closed;
				tag_length_q      <= n_len;
				phase_q           <= 1'b0;
			end else if (out_load) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TAG_CHARS_MAX; i++) begin
			if (consume && tag_wr && e_len == LENW'(i))
				tag_chars_q[i] <= lower_c[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (need_space && !phase_q) begin
				out_char_q <= CHAR_BITS'(CH_SP);
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= lower_c;
				out_last_q <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign last_of_item = out_last_q;

	a_space_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> out_char_q == CHAR_BITS'(CH_SP))
		else $error("non-final result is not a space");

	a_phase_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> valid_s1)
		else $error("space sent without a held character");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		tag_length_q <= LENW'(TAG_CHARS_MAX + 1))
		else $error("tag length beyond saturation");

	a_phase_char: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q && out_load |-> consume)
		else $error("character after space not transferred");

endmodule
